// ----- sv/cft_pkg.sv -----
package cft_pkg;

  localparam int unsigned SYM_W = 8;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned SYMBOLS_DEF = 256;
  localparam int unsigned COUNT_BITS_DEF = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_COUNT  = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  // Update broadcast to every cell in the cycle an item is transferred.
  typedef struct packed {
    logic             inc;
    logic             clr;
    logic [SYM_W-1:0] symbol;
  } cmd_t;

  // Control part of a lookup token moving down the chain.
  typedef struct packed {
    logic             valid;
    logic             in_table;
    logic [SYM_W-1:0] symbol;
  } tok_t;

endpackage

// ----- sv/cumulative_frequency_table.sv -----
// Cumulative frequency table for an arithmetic coder, built as a chain of
// SYMBOLS cells that each hold one symbol's count. Count and clear transfers
// update the cells as they are transferred, and the input stays ready. A lookup
// launches a token that passes one cell per cycle unless the chain is held,
// summing the counts of the symbols that order before the looked-up one, so the
// input stays not ready after a lookup transfer until the token leaves the last
// cell; the result then sits in an output register while count and clear
// transfers continue. A lookup whose result arrives while the previous result
// is still unaccepted holds the chain until the output is taken. Configuration
// writes are meant for idle periods only.
module cumulative_frequency_table #(
  parameter int unsigned SYMBOLS    = cft_pkg::SYMBOLS_DEF,
  parameter int unsigned COUNT_BITS = cft_pkg::COUNT_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic                                   cfg_wdata_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // Fields: symbol.
  input  logic [cft_pkg::SYM_W-1:0]              s_axis_tdata,
  // Fields: mode.
  input  logic [cft_pkg::MODE_W-1:0]             s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // Fields: entry_symbol, frequency, interval_low, interval_high, total.
  output logic [((cft_pkg::SYM_W+4*COUNT_BITS+7)/8)*8-1:0] m_axis_tdata,
  // Fields: present.
  output logic                                   m_axis_tuser
);
  import cft_pkg::*;

  localparam int unsigned OUT_W    = SYM_W + 4*COUNT_BITS;
  localparam int unsigned OUT_TD_W = ((OUT_W + 7) / 8) * 8;

  mode_e                 mode;
  logic                  s_fire;
  logic                  in_table;
  cmd_t                  cmd;
  logic                  adv;
  logic                  last_done;
  logic                  signed_order_q;
  logic                  busy_q, busy_d;
  logic [COUNT_BITS-1:0] total_q, total_d;
  logic                  out_valid_q, out_valid_d;
  logic [SYM_W-1:0]      out_sym_q;
  logic [COUNT_BITS-1:0] out_freq_q, out_low_q, out_total_q;
  logic [COUNT_BITS-1:0] out_high;

  tok_t                  tok  [SYMBOLS+1];
  logic [COUNT_BITS-1:0] acc  [SYMBOLS+1];
  logic [COUNT_BITS-1:0] freq [SYMBOLS+1];

  assign mode     = mode_e'(s_axis_tuser);
  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign in_table = {1'b0, s_axis_tdata} < (SYM_W+1)'(SYMBOLS);

  assign cmd.inc    = s_fire && (mode == MODE_COUNT) && in_table;
  assign cmd.clr    = s_fire && (mode == MODE_CLEAR);
  assign cmd.symbol = s_axis_tdata;

  assign tok[0].valid    = s_fire && (mode == MODE_LOOKUP);
  assign tok[0].in_table = in_table;
  assign tok[0].symbol   = s_axis_tdata;
  assign acc[0]          = '0;
  assign freq[0]         = '0;

  assign last_done = tok[SYMBOLS].valid;
  assign adv       = !(last_done && out_valid_q && !m_axis_tready);

  for (genvar i = 0; i < SYMBOLS; i++) begin : g_cell
    cft_cell #(
      .IDX       (i),
      .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .adv_i         (adv),
      .signed_order_i(signed_order_q),
      .tok_i         (tok[i]),
      .acc_i         (acc[i]),
      .freq_i        (freq[i]),
      .tok_o         (tok[i+1]),
      .acc_o         (acc[i+1]),
      .freq_o        (freq[i+1])
    );
  end

  assign s_axis_tready = !busy_q;

  always_comb begin
    busy_d = busy_q;
    if (tok[0].valid) begin
      busy_d = 1'b1;
    end else if (last_done && adv) begin
      busy_d = 1'b0;
    end
    total_d = total_q;
    if (cmd.clr) begin
      total_d = '0;
    end else if (cmd.inc) begin
      total_d = total_q + COUNT_BITS'(1);
    end
    out_valid_d = out_valid_q;
    if (last_done && adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_order_q <= 1'b1;
      busy_q         <= 1'b0;
      total_q        <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        signed_order_q <= cfg_wdata_i;
      end
      busy_q      <= busy_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_done && adv) begin
      out_sym_q   <= tok[SYMBOLS].symbol;
      out_freq_q  <= freq[SYMBOLS];
      out_low_q   <= acc[SYMBOLS];
      out_total_q <= total_q;
    end
  end

  assign out_high      = out_low_q + out_freq_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = (out_freq_q != '0);
  assign m_axis_tdata  = OUT_TD_W'({out_total_q, out_high, out_low_q, out_freq_q, out_sym_q});

endmodule

// ----- sv/cft_cell.sv -----
module cft_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned COUNT_BITS = cft_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cft_pkg::cmd_t         cmd_i,
  input  logic                  adv_i,
  input  logic                  signed_order_i,
  input  cft_pkg::tok_t         tok_i,
  input  logic [COUNT_BITS-1:0] acc_i,
  input  logic [COUNT_BITS-1:0] freq_i,
  output cft_pkg::tok_t         tok_o,
  output logic [COUNT_BITS-1:0] acc_o,
  output logic [COUNT_BITS-1:0] freq_o
);
  import cft_pkg::*;

  localparam logic [SYM_W-1:0] OWN = SYM_W'(IDX);

  logic [COUNT_BITS-1:0] count_q, count_d;
  tok_t                  tok_q;
  logic [COUNT_BITS-1:0] acc_q, acc_d;
  logic [COUNT_BITS-1:0] freq_q, freq_d;
  logic [SYM_W-1:0]      flip;
  logic [SYM_W-1:0]      own_key;
  logic [SYM_W-1:0]      tgt_key;
  logic                  orders_lower;

  assign flip         = {signed_order_i, {(SYM_W-1){1'b0}}};
  assign own_key      = OWN ^ flip;
  assign tgt_key      = tok_i.symbol ^ flip;
  assign orders_lower = tok_i.valid && tok_i.in_table && (own_key < tgt_key);

  always_comb begin
    count_d = count_q;
    if (cmd_i.clr) begin
      count_d = '0;
    end else if (cmd_i.inc && (cmd_i.symbol == OWN)) begin
      count_d = count_q + COUNT_BITS'(1);
    end
    acc_d  = orders_lower ? (acc_i + count_q) : acc_i;
    freq_d = (tok_i.in_table && (tok_i.symbol == OWN)) ? count_q : freq_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      tok_q   <= '0;
    end else begin
      count_q <= count_d;
      if (adv_i) begin
        tok_q <= tok_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      acc_q  <= acc_d;
      freq_q <= freq_d;
    end
  end

  assign tok_o  = tok_q;
  assign acc_o  = acc_q;
  assign freq_o = freq_q;

endmodule

// ----- sv/cft_checker.sv -----
module cft_checker #(
  parameter int unsigned COUNT_BITS = cft_pkg::COUNT_BITS_DEF
) (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   s_axis_tvalid,
  input logic                                   s_axis_tready,
  input logic [cft_pkg::MODE_W-1:0]             s_axis_tuser,
  input logic                                   m_axis_tvalid,
  input logic                                   m_axis_tready,
  input logic [((cft_pkg::SYM_W+4*COUNT_BITS+7)/8)*8-1:0] m_axis_tdata,
  input logic                                   m_axis_tuser
);
  import cft_pkg::*;

  localparam int unsigned F_LO = SYM_W;
  localparam int unsigned L_LO = SYM_W + COUNT_BITS;
  localparam int unsigned H_LO = SYM_W + 2*COUNT_BITS;

  logic [COUNT_BITS-1:0] f_freq, f_low, f_high;

  assign f_freq = m_axis_tdata[F_LO +: COUNT_BITS];
  assign f_low  = m_axis_tdata[L_LO +: COUNT_BITS];
  assign f_high = m_axis_tdata[H_LO +: COUNT_BITS];

  a_busy_after_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_LOOKUP) |=> !s_axis_tready)
    else $error("input ready right after a lookup transfer");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a lookup in flight");

  a_present_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == (f_freq != '0)))
    else $error("present flag disagrees with frequency");

  a_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (f_high == COUNT_BITS'(f_low + f_freq)))
    else $error("interval high is not low plus frequency");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind cumulative_frequency_table cft_checker #(
  .COUNT_BITS(COUNT_BITS)
) u_cft_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
